// ===== rtl/char_lcd_nibble_port_driver_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD nibble port driver.
// The macros expect a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_PORT_DRIVER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_PORT_DRIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CLNPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CLNPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLNPD_ASSERT_NOW(lbl, ante, cons, msg)
`define CLNPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/clnpd_pkg.sv =====
// ----------------------------------------------------------------------------
// clnpd_pkg
// Shared types, constants and the microcode table of the LCD port driver.
// ----------------------------------------------------------------------------
package clnpd_pkg;

  localparam int PC_W     = 7;
  localparam int DIGITS   = 5;
  localparam int CNT_W    = 3;

  localparam logic [PC_W-1:0] PC_CMD   = 7'd0;
  localparam logic [PC_W-1:0] PC_DATA  = 7'd7;
  localparam logic [PC_W-1:0] PC_INIT  = 7'd14;
  localparam logic [PC_W-1:0] PC_PRINT = 7'd70;
  localparam logic [PC_W-1:0] PC_DIGIT = 7'd71;
  localparam logic [PC_W-1:0] PC_LAST  = 7'd77;

  localparam logic [15:0] RECIP_10   = 16'hCCCD;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [3:0]  ASCII_DIGIT_HI = 4'h3;

  localparam logic [1:0] REG_RS_MASK     = 2'd0;
  localparam logic [1:0] REG_ENABLE_MASK = 2'd1;
  localparam logic [1:0] REG_PASS_MASK   = 2'd2;

  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_DATA  = 2'd1,
    OP_INIT  = 2'd2,
    OP_PRINT = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_DIR,
    ACT_NOTRS,
    ACT_RS_CLR,
    ACT_RS_SET,
    ACT_E_SET,
    ACT_NIB,
    ACT_E_CLR,
    ACT_DIV
  } act_t;

  typedef enum logic [1:0] {
    SRC_ROM,
    SRC_IN,
    SRC_DIGIT
  } src_t;

  typedef enum logic [1:0] {
    FLOW_NEXT,
    FLOW_END,
    FLOW_DIV,
    FLOW_DIGIT
  } flow_t;

  typedef struct packed {
    act_t       act;
    logic       emit;
    src_t       src;
    logic       hi;
    logic [7:0] byte_c;
    logic [5:0] wait_c;
    flow_t      flow;
  } uword_t;

  typedef struct packed {
    logic   start;
    logic   fire;
    uword_t word;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic div_again;
    logic digit_again;
  } status_t;

  function automatic uword_t mk(input act_t act, input logic emit, input src_t src,
                                input logic hi, input logic [7:0] b,
                                input logic [5:0] wt, input flow_t fl);
    uword_t w;
    w.act    = act;
    w.emit   = emit;
    w.src    = src;
    w.hi     = hi;
    w.byte_c = b;
    w.wait_c = wt;
    w.flow   = fl;
    return w;
  endfunction

  // One byte: register-select write, then two enable strobes.
  function automatic uword_t byte_step(input logic [2:0] k, input act_t rs_act,
                                       input logic rs_emit, input src_t src,
                                       input logic [7:0] b, input logic [5:0] w_rs,
                                       input logic [5:0] w_e, input flow_t fl_end);
    uword_t w;
    case (k)
      3'd0:    w = mk(rs_act, rs_emit, src, 1'b1, b, w_rs, FLOW_NEXT);
      3'd1:    w = mk(ACT_E_SET, 1'b1, src, 1'b1, b, w_e, FLOW_NEXT);
      3'd2:    w = mk(ACT_NIB, 1'b1, src, 1'b1, b, 6'd0, FLOW_NEXT);
      3'd3:    w = mk(ACT_E_CLR, 1'b1, src, 1'b1, b, 6'd0, FLOW_NEXT);
      3'd4:    w = mk(ACT_E_SET, 1'b1, src, 1'b0, b, 6'd0, FLOW_NEXT);
      3'd5:    w = mk(ACT_NIB, 1'b1, src, 1'b0, b, 6'd0, FLOW_NEXT);
      default: w = mk(ACT_E_CLR, 1'b1, src, 1'b0, b, 6'd0, fl_end);
    endcase
    return w;
  endfunction

  function automatic uword_t strobe_step(input logic [1:0] k, input logic [7:0] b,
                                         input logic [5:0] wt);
    uword_t w;
    case (k)
      2'd0:    w = mk(ACT_E_SET, 1'b1, SRC_ROM, 1'b1, b, wt, FLOW_NEXT);
      2'd1:    w = mk(ACT_NIB, 1'b1, SRC_ROM, 1'b1, b, 6'd0, FLOW_NEXT);
      default: w = mk(ACT_E_CLR, 1'b1, SRC_ROM, 1'b1, b, 6'd0, FLOW_NEXT);
    endcase
    return w;
  endfunction

  // Microcode table, addressed by the step counter.
  function automatic uword_t ucode(input logic [PC_W-1:0] a);
    logic [PC_W-1:0] i;
    logic [PC_W-1:0] t;
    uword_t          w;
    i = a - PC_INIT;
    t = '0;
    w = mk(ACT_NOP, 1'b0, SRC_ROM, 1'b0, 8'h00, 6'd0, FLOW_END);
    if (a < PC_DATA) begin
      w = byte_step(a[2:0], ACT_RS_CLR, 1'b1, SRC_IN, 8'h00, 6'd0, 6'd1, FLOW_END);
    end else if (a < PC_INIT) begin
      t = a - PC_DATA;
      w = byte_step(t[2:0], ACT_RS_SET, 1'b1, SRC_IN, 8'h00, 6'd0, 6'd1, FLOW_END);
    end else if (a < PC_PRINT) begin
      if (i == 7'd0) begin
        w = mk(ACT_DIR, 1'b1, SRC_ROM, 1'b1, 8'hFF, 6'd0, FLOW_NEXT);
      end else if (i == 7'd1) begin
        w = mk(ACT_NOTRS, 1'b1, SRC_ROM, 1'b1, 8'h00, 6'd50, FLOW_NEXT);
      end else if (i < 7'd5) begin
        t = i - 7'd2;
        w = strobe_step(t[1:0], 8'h30, 6'd0);
      end else if (i < 7'd8) begin
        t = i - 7'd5;
        w = strobe_step(t[1:0], 8'h30, 6'd5);
      end else if (i < 7'd11) begin
        t = i - 7'd8;
        w = strobe_step(t[1:0], 8'h30, 6'd5);
      end else if (i < 7'd14) begin
        t = i - 7'd11;
        w = strobe_step(t[1:0], 8'h20, 6'd5);
      end else if (i < 7'd21) begin
        // The first command's register-select write only updates the port image.
        t = i - 7'd14;
        w = byte_step(t[2:0], ACT_RS_CLR, 1'b0, SRC_ROM, 8'd40, 6'd0, 6'd6, FLOW_NEXT);
      end else if (i < 7'd28) begin
        t = i - 7'd21;
        w = byte_step(t[2:0], ACT_RS_CLR, 1'b1, SRC_ROM, 8'h08, 6'd0, 6'd1, FLOW_NEXT);
      end else if (i < 7'd35) begin
        t = i - 7'd28;
        w = byte_step(t[2:0], ACT_RS_CLR, 1'b1, SRC_ROM, 8'h01, 6'd0, 6'd1, FLOW_NEXT);
      end else if (i < 7'd42) begin
        t = i - 7'd35;
        w = byte_step(t[2:0], ACT_RS_CLR, 1'b1, SRC_ROM, 8'h06, 6'd5, 6'd1, FLOW_NEXT);
      end else if (i < 7'd49) begin
        t = i - 7'd42;
        w = byte_step(t[2:0], ACT_RS_CLR, 1'b1, SRC_ROM, 8'h0F, 6'd50, 6'd1, FLOW_NEXT);
      end else begin
        t = i - 7'd49;
        w = byte_step(t[2:0], ACT_RS_CLR, 1'b1, SRC_ROM, 8'h80, 6'd0, 6'd1, FLOW_END);
      end
    end else if (a == PC_PRINT) begin
      w = mk(ACT_DIV, 1'b0, SRC_DIGIT, 1'b1, 8'h00, 6'd0, FLOW_DIV);
    end else if (a <= PC_LAST) begin
      t = a - PC_DIGIT;
      w = byte_step(t[2:0], ACT_RS_SET, 1'b1, SRC_DIGIT, 8'h00, 6'd0, 6'd1, FLOW_DIGIT);
    end
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input op_t op);
    logic [PC_W-1:0] pc;
    unique case (op)
      OP_CMD:   pc = PC_CMD;
      OP_DATA:  pc = PC_DATA;
      OP_INIT:  pc = PC_INIT;
      OP_PRINT: pc = PC_PRINT;
      default:  pc = PC_CMD;
    endcase
    return pc;
  endfunction

endpackage

// ===== rtl/clnpd_seq.sv =====
// ----------------------------------------------------------------------------
// clnpd_seq
// Step counter and microcode fetch; issues one control word per step.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_port_driver_assert.svh"

module clnpd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  clnpd_pkg::status_t status,
  output clnpd_pkg::ctrl_t   ctrl
);

  logic                        active_r;
  logic                        active_nxt;
  logic [clnpd_pkg::PC_W-1:0]  pc_r;
  logic [clnpd_pkg::PC_W-1:0]  pc_nxt;
  clnpd_pkg::uword_t           word;
  logic                        start;
  logic                        fire;

  assign word     = clnpd_pkg::ucode(pc_r);
  assign in_stall = active_r;
  assign start    = in_valid && !active_r;
  assign fire     = active_r && (!word.emit || status.out_free);

  assign ctrl.start = start;
  assign ctrl.fire  = fire;
  assign ctrl.word  = word;

  always_comb begin
    active_nxt = active_r;
    pc_nxt     = pc_r;
    if (start) begin
      active_nxt = 1'b1;
      pc_nxt     = clnpd_pkg::entry_pc(clnpd_pkg::op_t'(in_operation));
    end else if (fire) begin
      case (word.flow)
        clnpd_pkg::FLOW_NEXT: pc_nxt = pc_r + 7'd1;
        clnpd_pkg::FLOW_END:  active_nxt = 1'b0;
        clnpd_pkg::FLOW_DIV: begin
          if (!status.div_again) begin
            pc_nxt = pc_r + 7'd1;
          end
        end
        default: begin
          if (status.digit_again) begin
            pc_nxt = clnpd_pkg::PC_DIGIT;
          end else begin
            active_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pc_r     <= clnpd_pkg::PC_CMD;
    end else begin
      active_r <= active_nxt;
      pc_r     <= pc_nxt;
    end
  end

  `CLNPD_ASSERT_NEXT(a_end_idles, fire && (word.flow == clnpd_pkg::FLOW_END), !active_r, "sequencer still busy after end step")
  `CLNPD_ASSERT_NOW(a_pc_range, active_r, pc_r <= clnpd_pkg::PC_LAST, "step counter outside the program")
  `CLNPD_ASSERT_NEXT(a_entry, start, active_r && (pc_r == clnpd_pkg::entry_pc(clnpd_pkg::op_t'($past(in_operation)))), "wrong entry step for item")

endmodule

// ===== rtl/clnpd_dp.sv =====
// ----------------------------------------------------------------------------
// clnpd_dp
// Port image, configuration masks, decimal digit unit and output register.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_port_driver_assert.svh"

module clnpd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_wdata,
  input  logic [15:0]        in_value,
  input  clnpd_pkg::ctrl_t   ctrl,
  output clnpd_pkg::status_t status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_port_value,
  output logic               out_to_direction,
  output logic [5:0]         out_wait_ms,
  output logic               out_last
);

  localparam int DIGITS = clnpd_pkg::DIGITS;
  localparam int CNT_W  = clnpd_pkg::CNT_W;

  logic [3:0]        rs_mask_r;
  logic [3:0]        enable_mask_r;
  logic [3:0]        pass_mask_r;
  logic [7:0]        image_r;
  logic [7:0]        image_nxt;
  logic [15:0]       val_r;
  logic [15:0]       val_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [3:0]        dig_r   [DIGITS];
  logic [3:0]        dig_nxt [DIGITS];
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [7:0]        out_port_value_r;
  logic              out_to_direction_r;
  logic [5:0]        out_wait_ms_r;
  logic              out_last_r;

  logic [7:0]        rs8;
  logic [7:0]        e8;
  logic [7:0]        keep8;
  logic [7:0]        byte_sel;
  logic [3:0]        nib;
  logic [7:0]        wv;
  logic              upd;
  logic              push;
  logic              pop;
  logic              emit_now;
  logic              last_now;
  logic [31:0]       prod;
  logic [15:0]       quo;
  logic [15:0]       quo10;
  logic [15:0]       rem;

  assign rs8   = {4'h0, rs_mask_r};
  assign e8    = {4'h0, enable_mask_r};
  assign keep8 = {4'h0, rs_mask_r | pass_mask_r};

  always_comb begin
    case (ctrl.word.src)
      clnpd_pkg::SRC_IN:    byte_sel = val_r[7:0];
      clnpd_pkg::SRC_DIGIT: byte_sel = {clnpd_pkg::ASCII_DIGIT_HI, dig_r[0]};
      default:              byte_sel = ctrl.word.byte_c;
    endcase
  end

  assign nib = ctrl.word.hi ? byte_sel[7:4] : byte_sel[3:0];

  always_comb begin
    unique case (ctrl.word.act)
      clnpd_pkg::ACT_DIR:    wv = 8'hFF;
      clnpd_pkg::ACT_NOTRS:  wv = ~rs8;
      clnpd_pkg::ACT_RS_CLR: wv = image_r & ~rs8;
      clnpd_pkg::ACT_RS_SET: wv = image_r | rs8;
      clnpd_pkg::ACT_E_SET:  wv = image_r | e8;
      clnpd_pkg::ACT_NIB:    wv = (image_r & keep8) | e8 | {nib, 4'h0};
      clnpd_pkg::ACT_E_CLR:  wv = image_r & ~e8;
      default:               wv = image_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.word.act) inside
      clnpd_pkg::ACT_NOP, clnpd_pkg::ACT_DIR, clnpd_pkg::ACT_DIV: upd = 1'b0;
      default:                                                    upd = 1'b1;
    endcase
  end

  // Divide by ten with a reciprocal multiply; exact for 16-bit values.
  assign prod  = 32'(val_r) * 32'(clnpd_pkg::RECIP_10);
  assign quo   = 16'(prod >> clnpd_pkg::RECIP_SHIFT);
  assign quo10 = (quo << 3) + (quo << 1);
  assign rem   = val_r - quo10;

  assign push     = ctrl.fire && (ctrl.word.act == clnpd_pkg::ACT_DIV);
  assign pop      = ctrl.fire && (ctrl.word.flow == clnpd_pkg::FLOW_DIGIT);
  assign emit_now = ctrl.fire && ctrl.word.emit;

  assign status.out_free    = !out_valid_r || !out_stall;
  assign status.div_again   = (quo != 16'd0) && (cnt_r < CNT_W'(DIGITS - 1));
  assign status.digit_again = (cnt_r != CNT_W'(1));

  assign last_now = (ctrl.word.flow == clnpd_pkg::FLOW_END) ||
                    ((ctrl.word.flow == clnpd_pkg::FLOW_DIGIT) && !status.digit_again);

  always_comb begin
    image_nxt = image_r;
    if (ctrl.fire && upd) begin
      image_nxt = wv;
    end
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    dig_nxt = dig_r;
    if (ctrl.start) begin
      val_nxt = in_value;
      cnt_nxt = '0;
    end else if (push) begin
      val_nxt    = quo;
      cnt_nxt    = cnt_r + CNT_W'(1);
      dig_nxt[0] = rem[3:0];
      for (int k = 1; k < DIGITS; k++) begin
        dig_nxt[k] = dig_r[k-1];
      end
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      for (int k = 0; k < DIGITS - 1; k++) begin
        dig_nxt[k] = dig_r[k+1];
      end
    end
    out_valid_nxt = out_valid_r;
    if (emit_now) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_mask_r     <= 4'd1;
      enable_mask_r <= 4'd2;
      pass_mask_r   <= 4'd0;
      image_r       <= 8'h00;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clnpd_pkg::REG_RS_MASK:     rs_mask_r     <= cfg_wdata;
          clnpd_pkg::REG_ENABLE_MASK: enable_mask_r <= cfg_wdata;
          clnpd_pkg::REG_PASS_MASK:   pass_mask_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      image_r     <= image_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    dig_r <= dig_nxt;
    if (emit_now) begin
      out_port_value_r   <= wv;
      out_to_direction_r <= (ctrl.word.act == clnpd_pkg::ACT_DIR);
      out_wait_ms_r      <= ctrl.word.wait_c;
      out_last_r         <= last_now;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_port_value   = out_port_value_r;
  assign out_to_direction = out_to_direction_r;
  assign out_wait_ms      = out_wait_ms_r;
  assign out_last         = out_last_r;

  `CLNPD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DIGITS), "digit count overflow")
  `CLNPD_ASSERT_NOW(a_pop_nonempty, pop, cnt_r != '0, "digit popped from empty stack")
  `CLNPD_ASSERT_NOW(a_dir_value, out_valid_r && out_to_direction_r, out_port_value_r == 8'hFF, "direction write with wrong value")

endmodule

// ===== rtl/char_lcd_nibble_port_driver.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_port_driver
// Turns command, data, initialize and print-decimal items into the run of
// 8-bit port writes that drives a character LCD in 4-bit mode.
// The input channel (in_valid, in_stall, in_operation, in_value) takes one
// item at a time; in_stall is high while an item is being worked off.
// The result channel (out_valid, out_stall, out_*) carries one port write per
// transfer, with out_wait_ms the delay before it and out_last on the final
// write of the item. The configuration port writes the three line masks; the
// user must write them only while the block is idle, which the block itself
// does not enforce. A microcode table runs one step per cycle while the
// result side does not stall: command and data items take 7 steps, initialize
// 56 and print decimal one division step per digit plus 7 per digit (8 to 40).
// The first write is registered from the first writing step, after the
// division steps for print decimal, and writes then follow one per cycle, but
// for one gap in initialize. The next item is taken the cycle after the last
// step. A stall on the result side holds the output register and freezes the
// step counter at the next step that writes. Reset restores the masks to
// 1, 2 and 0, clears the port image and empties the output register.
// ----------------------------------------------------------------------------
module char_lcd_nibble_port_driver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_port_value,
  output logic        out_to_direction,
  output logic [5:0]  out_wait_ms,
  output logic        out_last
);

  clnpd_pkg::ctrl_t   ctrl;
  clnpd_pkg::status_t status;

  clnpd_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .status       (status),
    .ctrl         (ctrl)
  );

  clnpd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_value         (in_value),
    .ctrl             (ctrl),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_port_value   (out_port_value),
    .out_to_direction (out_to_direction),
    .out_wait_ms      (out_wait_ms),
    .out_last         (out_last)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the character LCD nibble port driver
// Sends command, data, initialize and print-decimal items under several
// line mask settings and idle patterns. Each port write the block emits is
// compared field by field with a write predicted in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 64;
  localparam int PHASE_ITEMS    = 49;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    clnpd_pkg::op_t op;
    logic [15:0]    value;
    logic           drain_first;
  } lcd_item_t;

  typedef struct packed {
    logic [7:0] port_value;
    logic       to_direction;
    logic [5:0] wait_ms;
    logic       last;
  } lcd_write_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = clnpd_pkg::REG_RS_MASK;
  logic [3:0]  cfg_wdata = 4'h0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = clnpd_pkg::OP_CMD;
  logic [15:0] in_value = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_port_value;
  logic        out_to_direction;
  logic [5:0]  out_wait_ms;
  logic        out_last;

  lcd_item_t   pending_items[$];
  lcd_write_t  exp_writes[$];

  logic [3:0]  rs_line;
  logic [3:0]  en_line;
  logic [3:0]  keep_line;
  logic [7:0]  port_img;
  int unsigned wait_acc;

  idle_mode_t  idle_mode = IDLE_NONE;
  int          hold_req = 0;
  int          hold_seen;
  int          hold_left;
  int          idle_cycles;
  int          fail_count = 0;

  char_lcd_nibble_port_driver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_port_value   (out_port_value),
    .out_to_direction (out_to_direction),
    .out_wait_ms      (out_wait_ms),
    .out_last         (out_last)
  );

  always #1 clk = ~clk;

  function automatic void emit_write(input logic [7:0] v, input logic dir);
    lcd_write_t w;
    w.port_value   = v;
    w.to_direction = dir;
    w.wait_ms      = (wait_acc > 63) ? 6'd63 : 6'(wait_acc);
    w.last         = 1'b0;
    exp_writes.push_back(w);
    wait_acc = 0;
  endfunction

  function automatic void put_port(input logic [7:0] v);
    port_img = v;
    emit_write(v, 1'b0);
  endfunction

  function automatic void strobe_nibble(input logic [7:0] nib);
    logic [7:0] e;
    logic [7:0] keep;
    e    = {4'h0, en_line};
    keep = {4'h0, rs_line | keep_line};
    put_port(port_img | e);
    put_port((port_img & keep) | e | (nib & 8'hF0));
    put_port(port_img & ~e);
  endfunction

  function automatic void send_byte(input logic [7:0] b, input logic is_data,
                                    input logic skip_rs);
    logic [7:0] rs;
    logic [7:0] v;
    rs = {4'h0, rs_line};
    v  = is_data ? (port_img | rs) : (port_img & ~rs);
    if (skip_rs) begin
      port_img = v;
    end else begin
      put_port(v);
    end
    wait_acc += 1;
    strobe_nibble(b);
    strobe_nibble({b[3:0], 4'h0});
  endfunction

  function automatic void init_writes();
    emit_write(8'hFF, 1'b1);
    wait_acc += 50;
    put_port(~{4'h0, rs_line});
    repeat (3) begin
      strobe_nibble(8'h30);
      wait_acc += 5;
    end
    strobe_nibble(8'h20);
    wait_acc += 5;
    // The first command reuses the value already on the port.
    send_byte(8'd40, 1'b0, 1'b1);
    send_byte(8'h08, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    wait_acc += 5;
    send_byte(8'h06, 1'b0, 1'b0);
    wait_acc += 50;
    send_byte(8'h0F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
  endfunction

  function automatic void print_writes(input logic [15:0] n);
    logic [3:0]  digit [5];
    int          cnt;
    int unsigned rest;
    cnt  = 0;
    rest = n;
    do begin
      digit[cnt] = 4'(rest % 10);
      rest       = rest / 10;
      cnt++;
    end while (rest != 0 && cnt < 5);
    while (cnt > 0) begin
      cnt--;
      send_byte(8'd48 + {4'h0, digit[cnt]}, 1'b1, 1'b0);
    end
  endfunction

  function automatic void predict_item(input clnpd_pkg::op_t op, input logic [15:0] v);
    lcd_write_t tail;
    wait_acc = 0;
    case (op)
      clnpd_pkg::OP_CMD:  send_byte(v[7:0], 1'b0, 1'b0);
      clnpd_pkg::OP_DATA: send_byte(v[7:0], 1'b1, 1'b0);
      clnpd_pkg::OP_INIT: init_writes();
      default:            print_writes(v);
    endcase
    tail = exp_writes.pop_back();
    tail.last = 1'b1;
    exp_writes.push_back(tail);
  endfunction

  function automatic lcd_item_t lcd_item(input clnpd_pkg::op_t op, input logic [15:0] v,
                                         input logic drain);
    lcd_item_t it;
    it.op          = op;
    it.value       = v;
    it.drain_first = drain;
    return it;
  endfunction

  function automatic lcd_item_t random_item();
    clnpd_pkg::op_t op;
    logic [15:0]    v;
    op = clnpd_pkg::op_t'($urandom_range(0, 3));
    v  = 16'($urandom());
    if (op == clnpd_pkg::OP_PRINT) begin
      case ($urandom_range(0, 3))
        0:       v = 16'($urandom_range(0, 9));
        1:       v = 16'($urandom_range(10, 999));
        default: v = 16'($urandom());
      endcase
      if ($urandom_range(0, 15) == 0) begin
        v = 16'h0000;
      end
    end
    return lcd_item(op, v, $urandom_range(0, 15) == 0);
  endfunction

  function automatic logic sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 49;
      IDLE_BOTH: return $urandom_range(0, 99) < 26;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 49;
      IDLE_BOTH: return $urandom_range(0, 99) < 26;
      default:   return 1'b0;
    endcase
  endfunction

  // An item marked drain_first is held back until every expected write is in.
  always @(posedge clk) begin : sender
    lcd_item_t it;
    logic      offer;
    it    = '0;
    offer = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(clnpd_pkg::op_t'(in_operation), in_value);
      end
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() != 0 && !sender_idles()) begin
          if (!pending_items[0].drain_first || exp_writes.size() == 0) begin
            it    = pending_items.pop_front();
            offer = 1'b1;
          end
        end
        in_valid <= offer;
        if (offer) begin
          in_operation <= it.op;
          in_value     <= it.value;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_stalls();
    end
  end

  always @(posedge clk) begin : result_mon
    lcd_write_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_writes.size() == 0) begin
        $error("port write 0x%02h (direction %0b) with no write expected",
               out_port_value, out_to_direction);
        fail_count++;
      end else begin
        want = exp_writes.pop_front();
        if (out_port_value !== want.port_value) begin
          $error("port_value: expected 0x%02h, got 0x%02h", want.port_value, out_port_value);
          fail_count++;
        end
        if (out_to_direction !== want.to_direction) begin
          $error("to_direction: expected %0b, got %0b", want.to_direction, out_to_direction);
          fail_count++;
        end
        if (out_wait_ms !== want.wait_ms) begin
          $error("wait_ms: expected %0d, got %0d", want.wait_ms, out_wait_ms);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || exp_writes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      clnpd_pkg::REG_RS_MASK:     rs_line   <= v;
      clnpd_pkg::REG_ENABLE_MASK: en_line   <= v;
      default:                    keep_line <= v;
    endcase
  endtask

  task automatic start_phase(input logic [3:0] rs, input logic [3:0] en,
                             input logic [3:0] keep, input idle_mode_t m,
                             input logic long_hold);
    wait_drained();
    write_reg(clnpd_pkg::REG_RS_MASK, rs);
    write_reg(clnpd_pkg::REG_ENABLE_MASK, en);
    write_reg(clnpd_pkg::REG_PASS_MASK, keep);
    @(posedge clk);
    cfg_we    <= 1'b0;
    idle_mode <= m;
    if (long_hold) begin
      hold_req <= hold_req + 1;
    end
    @(negedge clk);
    repeat (PHASE_ITEMS) pending_items.push_back(random_item());
  endtask

  initial begin : stimulus
    rs_line   = 4'd1;
    en_line   = 4'd2;
    keep_line = 4'd0;
    port_img  = 8'h00;
    wait_acc  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pending_items.push_back(lcd_item(clnpd_pkg::OP_INIT, 16'hFFFF, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_CMD, 16'h0000, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_CMD, 16'hFFFF, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_DATA, 16'h0000, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_DATA, 16'hFFFF, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_CMD, 16'hA55A, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_DATA, 16'h5AA5, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_PRINT, 16'd0, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_PRINT, 16'd65535, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_PRINT, 16'd9, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_PRINT, 16'd10, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_PRINT, 16'd10000, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_PRINT, 16'd12345, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_PRINT, 16'h8000, 1'b0));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_INIT, 16'h0000, 1'b1));
    pending_items.push_back(lcd_item(clnpd_pkg::OP_DATA, 16'h00FF, 1'b0));
    repeat (40) pending_items.push_back(random_item());

    start_phase(4'd0, 4'd0, 4'd0, IDLE_NONE, 1'b1);
    start_phase(4'd15, 4'd15, 4'd15, IDLE_SEND, 1'b0);
    start_phase(4'd3, 4'd6, 4'd12, IDLE_RECV, 1'b0);
    start_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), IDLE_BOTH, 1'b0);
    start_phase(4'd1, 4'd2, 4'd0, IDLE_BOTH, 1'b1);
    start_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), IDLE_RECV, 1'b0);
    start_phase(4'd8, 4'd1, 4'd15, IDLE_SEND, 1'b0);
    start_phase(4'd4, 4'd8, 4'd5, IDLE_NONE, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
